>>> hdl/double_hash_table_engine_defines.svh
// ----------------------------------------------------------------------------
// Double hash table engine: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define DHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dht_pkg.sv
// ----------------------------------------------------------------------------
// Double hash table engine package
// Types, codes and default sizes shared by the engine and its parts.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int DHT_SLOTS  = 127;
  localparam int CODE_W     = 32;
  localparam int VALUE_W    = 32;
  localparam int SLOT_IDX_W = 7;
  // code bits folded into the residues per cycle
  localparam int HASH_BITS  = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_EXISTS  = 2'd1,
    RES_FULL    = 2'd2,
    RES_MISSING = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } dht_state_e;

endpackage

>>> hdl/double_hash_table_engine.sv
// ----------------------------------------------------------------------------
// Double hash table engine
// Open-addressing key/payload table with double-hashing probe walk:
// insert, delete, lookup and update on 32-bit keys.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | dir
//  ---------+------------------------------------------------+-----
//  request  | in_valid_i/in_ready_o, operation_i,            | in
//           | item_code_i, item_value_i                      |
//  result   | out_valid_o/out_ready_i, status_o,             | out
//           | found_value_o, slot_index_o                    |
//
// One request at a time: accept, compute the two residues, then per probe a
// status/entry RAM read followed by a compare, and at the end write back and
// load the result. After reset a clearing pass marks all SLOTS entries empty,
// with in_ready_o low. A stalled result holds the engine in its final state
// only once the next request has reached it.
// ----------------------------------------------------------------------------
`include "double_hash_table_engine_defines.svh"

module double_hash_table_engine import dht_pkg::*; #(
  parameter int SLOTS = DHT_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [CODE_W-1:0]     item_code_i,
  input  logic [VALUE_W-1:0]    item_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [VALUE_W-1:0]    found_value_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int TW = $clog2(SLOTS + 1);
  localparam int EW = CODE_W + VALUE_W;

  dht_state_e state_q, state_d;

  logic [IW-1:0]      clr_cnt_q, clr_cnt_d;
  op_e                op_q, op_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic [IW-1:0]      step_q, step_d;
  logic [TW-1:0]      try_q, try_d;
  logic               tomb_vld_q, tomb_vld_d;
  logic [IW-1:0]      tomb_q, tomb_d;

  // outcome of the walk, applied in the final state
  res_e               fin_status_q, fin_status_d;
  logic [IW-1:0]      fin_slot_q, fin_slot_d;
  logic [VALUE_W-1:0] fin_found_q, fin_found_d;
  logic               fin_wst_q, fin_wst_d;
  slot_st_e           fin_wst_val_q, fin_wst_val_d;
  logic               fin_went_q, fin_went_d;

  logic                  out_valid_q, out_valid_d;
  res_e                  out_status_q, out_status_d;
  logic [VALUE_W-1:0]    out_found_q, out_found_d;
  logic [SLOT_IDX_W-1:0] out_slot_q, out_slot_d;

  // hash units
  logic          hash_start;
  logic          pos_done, step_done;
  logic [IW-1:0] pos_res, step_res;

  // memory ports
  logic          st_we, ent_we, mem_re;
  logic [IW-1:0] st_waddr;
  logic [1:0]    st_wdata, st_rdata;
  logic [EW-1:0] ent_rdata;

  dht_mod_unit #(
    .MODULUS (SLOTS),
    .RW      (IW)
  ) u_pos_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (hash_start),
    .code_i    (item_code_i),
    .done_o    (pos_done),
    .residue_o (pos_res)
  );

  dht_mod_unit #(
    .MODULUS (SLOTS - 1),
    .RW      (IW)
  ) u_step_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (hash_start),
    .code_i    (item_code_i),
    .done_o    (step_done),
    .residue_o (step_res)
  );

  dht_ram #(
    .WIDTH (2),
    .DEPTH (SLOTS)
  ) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (st_rdata)
  );

  dht_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (fin_slot_q),
    .wdata_i ({code_q, value_q}),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    logic          is_empty, is_match, is_tomb, tomb_now_vld, out_free;
    logic [IW-1:0] tomb_now;
    logic [IW:0]   pos_sum;
    logic [TW-1:0] try_nxt;
    slot_st_e      rd_st;

    state_d       = state_q;
    clr_cnt_d     = clr_cnt_q;
    op_d          = op_q;
    code_d        = code_q;
    value_d       = value_q;
    pos_d         = pos_q;
    step_d        = step_q;
    try_d         = try_q;
    tomb_vld_d    = tomb_vld_q;
    tomb_d        = tomb_q;
    fin_status_d  = fin_status_q;
    fin_slot_d    = fin_slot_q;
    fin_found_d   = fin_found_q;
    fin_wst_d     = fin_wst_q;
    fin_wst_val_d = fin_wst_val_q;
    fin_went_d    = fin_went_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_status_d  = out_status_q;
    out_found_d   = out_found_q;
    out_slot_d    = out_slot_q;

    in_ready_o = 1'b0;
    hash_start = 1'b0;
    mem_re     = 1'b0;
    st_we      = 1'b0;
    st_waddr   = fin_slot_q;
    st_wdata   = fin_wst_val_q;
    ent_we     = 1'b0;
    out_free   = ~out_valid_q | out_ready_i;

    rd_st    = slot_st_e'(st_rdata);
    is_empty = 1'b0;
    is_match = 1'b0;
    is_tomb  = 1'b0;
    unique case (rd_st)
      ST_EMPTY: is_empty = 1'b1;
      ST_USED:  is_match = (ent_rdata[EW-1:VALUE_W] == code_q);
      ST_TOMB:  is_tomb  = 1'b1;
      default:  ;
    endcase
    tomb_now_vld = tomb_vld_q | is_tomb;
    tomb_now     = tomb_vld_q ? tomb_q : pos_q;
    pos_sum      = {1'b0, pos_q} + {1'b0, step_q};
    if (pos_sum >= (IW+1)'(SLOTS)) begin
      pos_sum = pos_sum - (IW+1)'(SLOTS);
    end
    try_nxt = try_q + 1'b1;

    unique case (state_q)
      S_CLEAR: begin
        st_we     = 1'b1;
        st_waddr  = clr_cnt_q;
        st_wdata  = ST_EMPTY;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          hash_start = 1'b1;
          op_d       = op_e'(operation_i);
          code_d     = item_code_i;
          value_d    = item_value_i;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (pos_done && step_done) begin
          pos_d      = pos_res;
          step_d     = step_res + 1'b1;
          try_d      = '0;
          tomb_vld_d = 1'b0;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        fin_status_d = RES_MISSING;
        fin_slot_d   = '0;
        fin_found_d  = '0;
        fin_wst_d    = 1'b0;
        fin_went_d   = 1'b0;
        if (is_match) begin
          fin_slot_d   = pos_q;
          fin_status_d = RES_OK;
          unique case (op_q)
            OP_INSERT: fin_status_d = RES_EXISTS;
            OP_DELETE: begin
              fin_wst_d     = 1'b1;
              fin_wst_val_d = ST_TOMB;
            end
            OP_LOOKUP: fin_found_d = ent_rdata[VALUE_W-1:0];
            OP_UPDATE: fin_went_d = 1'b1;
            default:   ;
          endcase
          state_d = S_DONE;
        end else if (is_empty || try_nxt == TW'(SLOTS)) begin
          // walk over without a match
          if (op_q == OP_INSERT) begin
            if (tomb_now_vld || is_empty) begin
              fin_status_d  = RES_OK;
              fin_slot_d    = tomb_now_vld ? tomb_now : pos_q;
              fin_wst_d     = 1'b1;
              fin_wst_val_d = ST_USED;
              fin_went_d    = 1'b1;
            end else begin
              fin_status_d = RES_FULL;
            end
          end
          state_d = S_DONE;
        end else begin
          tomb_vld_d = tomb_now_vld;
          tomb_d     = tomb_now;
          try_d      = try_nxt;
          pos_d      = pos_sum[IW-1:0];
          state_d    = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          st_we        = fin_wst_q;
          ent_we       = fin_went_q;
          out_valid_d  = 1'b1;
          out_status_d = fin_status_q;
          out_found_d  = fin_found_q;
          out_slot_d   = SLOT_IDX_W'({{SLOT_IDX_W{1'b0}}, fin_slot_q});
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      tomb_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      tomb_vld_q  <= tomb_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    code_q        <= code_d;
    value_q       <= value_d;
    pos_q         <= pos_d;
    step_q        <= step_d;
    try_q         <= try_d;
    tomb_q        <= tomb_d;
    fin_status_q  <= fin_status_d;
    fin_slot_q    <= fin_slot_d;
    fin_found_q   <= fin_found_d;
    fin_wst_q     <= fin_wst_d;
    fin_wst_val_q <= fin_wst_val_d;
    fin_went_q    <= fin_went_d;
    out_status_q  <= out_status_d;
    out_found_q   <= out_found_d;
    out_slot_q    <= out_slot_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_found_q;
  assign slot_index_o  = out_slot_q;

  // no table writes while a probe walk reads it
  `DHT_ASSERT_IMP(a_no_wr_in_walk, (state_q == S_READ || state_q == S_CHECK), (!st_we && !ent_we), "table write during probe walk")

  // probe address and stride stay inside the table
  `DHT_ASSERT_IMP(a_pos_range, (state_q == S_READ), (({1'b0, pos_q} < (IW+1)'(SLOTS)) && (step_q != '0)), "probe position or stride out of range")

  // a result is only loaded into a free output register
  `DHT_ASSERT_NXT(a_result_once, (state_q == S_DONE && out_valid_q && !out_ready_i), (state_q == S_DONE), "result left final state while output stalled")

endmodule

>>> hdl/dht_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dht_mod_unit.sv
// ----------------------------------------------------------------------------
// Residue unit
// Reduces a 32-bit code modulo a constant, HASH_BITS code bits per cycle,
// by shift and conditional subtract.
// ----------------------------------------------------------------------------
module dht_mod_unit import dht_pkg::*; #(
  parameter int MODULUS = 127,
  parameter int RW      = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CODE_W-1:0] code_i,
  output logic              done_o,
  output logic [RW-1:0]     residue_o
);

  localparam int NSTEP = CODE_W / HASH_BITS;
  localparam int CW    = $clog2(NSTEP + 1);

  logic [CODE_W-1:0] sh_q, sh_d;
  logic [RW-1:0]     r_q, r_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  always_comb begin
    logic [RW:0] tmp;
    logic [RW-1:0] r;
    r     = r_q;
    tmp   = '0;
    sh_d  = sh_q;
    r_d   = r_q;
    cnt_d = cnt_q;
    if (start_i) begin
      sh_d  = code_i;
      r_d   = '0;
      cnt_d = CW'(NSTEP);
    end else if (cnt_q != '0) begin
      for (int i = 0; i < HASH_BITS; i++) begin
        tmp = {r, sh_q[CODE_W-1-i]};
        if (tmp >= (RW+1)'(MODULUS)) begin
          tmp = tmp - (RW+1)'(MODULUS);
        end
        r = tmp[RW-1:0];
      end
      r_d   = r;
      sh_d  = sh_q << HASH_BITS;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q  <= r_d;
  end

  assign done_o    = (cnt_q == '0);
  assign residue_o = r_q;

endmodule
